// ===== sv/rjd_pkg.sv =====
// Package for the retry job deque dispatcher: sizes, request codes,
// the slot and command types, and width helpers. No dependencies.
`default_nettype none
package rjd_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PARAM_BITS  = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W       = PTR_W + 1;

  localparam int REQ_W   = 3;
  localparam int JOB_W   = 8;
  localparam int RETRY_W = 8;
  localparam int PRM_W   = 16;
  localparam int QLVL_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_PUSH   = 3'd1,
    REQ_TICK   = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_FLUSH  = 3'd4
  } req_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [JOB_W-1:0]      job;
    logic [PARAM_BITS-1:0] param;
    logic [RETRY_W-1:0]    retries;
  } slot_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  // Port parameter to stored width.
  function automatic logic [PARAM_BITS-1:0] param_in(input logic [PRM_W-1:0] v);
    logic [PARAM_BITS+PRM_W-1:0] ext;
    ext = {{PARAM_BITS{1'b0}}, v};
    return ext[PARAM_BITS-1:0];
  endfunction

  // Stored parameter to port width.
  function automatic logic [PRM_W-1:0] param_out(input logic [PARAM_BITS-1:0] v);
    logic [PARAM_BITS+PRM_W-1:0] ext;
    ext = {{PRM_W{1'b0}}, v};
    return ext[PRM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rjd_ctrl.sv =====
// Controller for the retry job deque dispatcher: two-state sequencer
// and result strobe. Depends on rjd_pkg.
`default_nettype none
module rjd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output rjd_pkg::ctrl_cmd_t     cmd
);
  import rjd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;

  a_exec_then_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("execute cycle not followed by result strobe");

  a_strobe_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an execute cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start execution");

endmodule
`default_nettype wire

// ===== sv/rjd_datapath.sv =====
// Datapath for the retry job deque dispatcher: slot memory, head and
// tail pointers, current-job register and result registers. Depends on rjd_pkg.
`default_nettype none
module rjd_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rjd_pkg::ctrl_cmd_t          cmd,
  input  wire logic [rjd_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [rjd_pkg::JOB_W-1:0]   in_job_id,
  input  wire logic [rjd_pkg::PRM_W-1:0]   in_job_param,
  input  wire logic [rjd_pkg::RETRY_W-1:0] in_retry_count,
  output logic                             out_call_valid,
  output logic [rjd_pkg::JOB_W-1:0]        out_call_job,
  output logic [rjd_pkg::PRM_W-1:0]        out_call_param,
  output logic                             out_accepted,
  output logic [rjd_pkg::QLVL_W-1:0]       out_queue_level,
  output logic                             out_active
);
  import rjd_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LVL_W-1:0] DEPTH_L  = LVL_W'(QUEUE_DEPTH);

  slot_t mem [QUEUE_DEPTH];
  slot_t rd_data_r;

  logic [REQ_W-1:0]      req_r;
  logic [JOB_W-1:0]      id_r;
  logic [PARAM_BITS-1:0] prm_r;
  logic [RETRY_W-1:0]    rc_r;

  logic [PTR_W-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [JOB_W-1:0]      cur_job_r, cur_job_nxt;
  logic [PARAM_BITS-1:0] cur_prm_r, cur_prm_nxt;
  logic [RETRY_W-1:0]    cur_rc_r, cur_rc_nxt;

  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [PTR_W-1:0]      tail_inc, head_inc, head_dec;
  logic                  call_v;
  logic                  acc;
  logic [LVL_W-1:0]      level;
  logic [LVL_W+QLVL_W-1:0] level_ext;

  logic                  call_valid_r, accepted_r, active_r;
  logic [JOB_W-1:0]      call_job_r;
  logic [PRM_W-1:0]      call_param_r;
  logic [QLVL_W-1:0]     queue_level_r;

  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign head_dec = (head_r == '0) ? PTR_LAST : head_r - PTR_W'(1);

  // The head slot is read every cycle; during execute it holds the
  // entry at the current head, since nothing is written in between.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[head_r];
    if (wr_en) begin
      mem[wr_addr] <= '{job: id_r, param: prm_r, retries: rc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      id_r  <= in_job_id;
      prm_r <= param_in(in_job_param);
      rc_r  <= in_retry_count;
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cur_job_nxt = cur_job_r;
    cur_prm_nxt = cur_prm_r;
    cur_rc_nxt  = cur_rc_r;
    wr_en       = 1'b0;
    wr_addr     = tail_r;
    call_v      = 1'b0;
    acc         = 1'b0;
    if (cmd.exec) begin
      unique case (req_r)
        REQ_APPEND: begin
          if (tail_inc != head_r) begin
            wr_en    = 1'b1;
            wr_addr  = tail_r;
            tail_nxt = tail_inc;
            acc      = 1'b1;
          end
        end
        REQ_PUSH: begin
          if (head_dec != tail_r) begin
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            head_nxt = head_dec;
            acc      = 1'b1;
          end
        end
        REQ_TICK: begin
          if (cur_job_r != '0) begin
            if (cur_rc_r != '0) begin
              cur_rc_nxt = cur_rc_r - RETRY_W'(1);
              call_v     = 1'b1;
            end else begin
              cur_job_nxt = '0;
              cur_prm_nxt = '0;
              cur_rc_nxt  = '0;
            end
          end else if (head_r != tail_r) begin
            cur_job_nxt = rd_data_r.job;
            cur_prm_nxt = rd_data_r.param;
            cur_rc_nxt  = rd_data_r.retries;
            head_nxt    = head_inc;
          end
        end
        REQ_CLEAR: begin
          if (id_r == '0 || id_r == cur_job_r) begin
            cur_job_nxt = '0;
            cur_prm_nxt = '0;
            cur_rc_nxt  = '0;
          end
        end
        REQ_FLUSH: begin
          head_nxt    = '0;
          tail_nxt    = '0;
          cur_job_nxt = '0;
          cur_prm_nxt = '0;
          cur_rc_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tail_nxt >= head_nxt) begin
      level = {1'b0, tail_nxt} - {1'b0, head_nxt};
    end else begin
      level = {1'b0, tail_nxt} + DEPTH_L - {1'b0, head_nxt};
    end
    level_ext = {{QLVL_W{1'b0}}, level};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      cur_job_r <= '0;
      cur_prm_r <= '0;
      cur_rc_r  <= '0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cur_job_r <= cur_job_nxt;
      cur_prm_r <= cur_prm_nxt;
      cur_rc_r  <= cur_rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      call_valid_r  <= call_v;
      call_job_r    <= call_v ? cur_job_r : '0;
      call_param_r  <= call_v ? param_out(cur_prm_r) : '0;
      accepted_r    <= acc;
      queue_level_r <= level_ext[QLVL_W-1:0];
      active_r      <= (cur_job_nxt != '0);
    end
  end

  assign out_call_valid  = call_valid_r;
  assign out_call_job    = call_job_r;
  assign out_call_param  = call_param_r;
  assign out_accepted    = accepted_r;
  assign out_queue_level = queue_level_r;
  assign out_active      = active_r;

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> ($stable(head_r) && $stable(tail_r) && $stable(cur_job_r)))
    else $error("queue state changed outside an execute cycle");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_r} < DEPTH_L) && ({1'b0, tail_r} < DEPTH_L))
    else $error("queue pointer out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && req_r == REQ_FLUSH) |=> (head_r == '0 && tail_r == '0 && cur_job_r == '0))
    else $error("flush did not empty the queue");

endmodule
`default_nettype wire

// ===== sv/retry_job_deque_dispatcher.sv =====
// Top level of the retry job deque dispatcher: joins the controller
// and the datapath. Depends on rjd_pkg, rjd_ctrl and rjd_datapath.
`default_nettype none
// An item is taken when start is high and busy is low. Busy is high while
// the controller is in its execute state after the accept, because the
// head slot of the queue memory has a registered read port and a tick that
// loads a job must wait for that read. The result is shown for exactly one
// cycle with out_valid, in the cycle after execute, and cannot be held off;
// a new item may be accepted in that same cycle, while the previous result
// is shown. Every item yields exactly one result.
module retry_job_deque_dispatcher (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rjd_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [rjd_pkg::JOB_W-1:0]   in_job_id,
  input  wire logic [rjd_pkg::PRM_W-1:0]   in_job_param,
  input  wire logic [rjd_pkg::RETRY_W-1:0] in_retry_count,
  output logic                             out_valid,
  output logic                             out_call_valid,
  output logic [rjd_pkg::JOB_W-1:0]        out_call_job,
  output logic [rjd_pkg::PRM_W-1:0]        out_call_param,
  output logic                             out_accepted,
  output logic [rjd_pkg::QLVL_W-1:0]       out_queue_level,
  output logic                             out_active
);
  import rjd_pkg::*;

  ctrl_cmd_t cmd;

  rjd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rjd_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_job_id       (in_job_id),
    .in_job_param    (in_job_param),
    .in_retry_count  (in_retry_count),
    .out_call_valid  (out_call_valid),
    .out_call_job    (out_call_job),
    .out_call_param  (out_call_param),
    .out_accepted    (out_accepted),
    .out_queue_level (out_queue_level),
    .out_active      (out_active)
  );

endmodule
`default_nettype wire
